FILE: design/tds_pkg.sv
// ----------------------------------------------------------------------------
// Table distribution sampler package
// Shared widths, constants and codes of the sampler core and its table RAM.
// ----------------------------------------------------------------------------
package tds_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 100;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // Field widths.
  localparam int KIND_W    = 1;
  localparam int EIDX_W    = 7;
  localparam int ENTRY_W   = 32;
  localparam int PROB_W    = 32;
  localparam int OUT_W     = 56;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 40;
  localparam int STEP_W    = 32;

  // Internal widths.
  localparam int PROD_W     = PROB_W + IDX_W;   // probability times table size
  localparam int X_W        = ENTRY_W + 1;      // Q9.24 table value or probability
  localparam int PART_W     = X_W + CFG_W / 2;  // one partial product
  localparam int SUM_W      = PART_W + CFG_W / 2 + 1;
  localparam int MAG_W      = 59;               // magnitude, capped at 2^58
  localparam int VAL_W      = 60;               // nonnegative signed value
  localparam int XQ_W       = VAL_W - 16 + 1;   // rounding dividend
  localparam int DIV_STAGES = XQ_W;
  localparam int DIV_LAST   = DIV_STAGES - 1;

  localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 1'b1;

  // Distribution modes.
  localparam logic MODE_UNIFORM = 1'b0;
  localparam logic MODE_TABLE   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIST_MODE  = 2'd0,
    REG_MIN_VALUE  = 2'd1,
    REG_MEAN_VALUE = 2'd2,
    REG_ROUND_STEP = 2'd3
  } cfg_reg_t;

endpackage

FILE: design/table_distribution_sampler_core.sv
// ----------------------------------------------------------------------------
// Table distribution sampler core
// Shapes a uniform Q0.32 fraction into a Q40.16 sample, by a piecewise linear
// inverse CDF table held in RAM or by a uniform law, with optional rounding.
// ----------------------------------------------------------------------------
// One beat per cycle, draw or table write, in any mix, while the skid entry is empty.
// The 45 one-bit stages of the rounding remainder pipe set most of the latency;
// six datapath stages after the table read and the output register add the rest.
// A table write is seen by a draw accepted in the very next cycle.
// Reset clears valid bits and loads register defaults; table entries stay
// undefined until written and get no clearing pass.
module table_distribution_sampler_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tds_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tds_pkg::KIND_W-1:0]        in_kind,
  input  logic [tds_pkg::EIDX_W-1:0]        in_entry_index,
  input  logic [tds_pkg::ENTRY_W-1:0]       in_entry_base,
  input  logic [tds_pkg::ENTRY_W-1:0]       in_entry_range,
  input  logic [tds_pkg::PROB_W-1:0]        in_probability,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tds_pkg::OUT_W-1:0]         out_sample_value
);

  // Configuration and values derived from it.
  logic                          dist_mode_r;
  logic [tds_pkg::CFG_W-1:0]     min_value_r;
  logic [tds_pkg::CFG_W-1:0]     mean_value_r;
  logic [tds_pkg::STEP_W-1:0]    round_step_r;
  logic [tds_pkg::CFG_W-1:0]     d_r;
  logic                          neg_r;
  logic                          rs_nz_r;

  // Pipeline control.
  logic                          pipe_en;
  logic                          in_acc;
  logic                          ram_we;
  logic [tds_pkg::PROD_W-1:0]    sel_prod;
  logic [2*tds_pkg::ENTRY_W-1:0] ram_rdata;

  // Pipeline stages.
  logic                          s1_vld_r;
  logic [tds_pkg::PROB_W-1:0]    s1_p_r;
  logic [tds_pkg::PROB_W-1:0]    s1_f_r;
  logic [2*tds_pkg::ENTRY_W-1:0] rf_prod;
  logic                          s2_vld_r;
  logic [tds_pkg::ENTRY_W-1:0]   s2_base_r;
  logic [tds_pkg::ENTRY_W-1:0]   s2_rf_r;
  logic [tds_pkg::PROB_W-1:0]    s2_p_r;
  logic                          s3_vld_r;
  logic [tds_pkg::X_W-1:0]       s3_x_r;
  logic                          s4_vld_r;
  logic [tds_pkg::PART_W-1:0]    s4_pl_r;
  logic [tds_pkg::PART_W-1:0]    s4_ph_r;
  logic [tds_pkg::SUM_W-1:0]     s5_sum;
  logic [tds_pkg::SUM_W-1:0]     s5_shift;
  logic                          s5_vld_r;
  logic [tds_pkg::MAG_W-1:0]     s5_mag_r;
  logic [tds_pkg::VAL_W:0]       s6_base16;
  logic                          s6_vld_r;
  logic [tds_pkg::VAL_W:0]       s6_v_r;
  logic [tds_pkg::VAL_W:0]       s7_sum;
  logic                          s7_vld_r;
  logic                          s7_neg_r;
  logic [tds_pkg::VAL_W-1:0]     s7_val_r;

  // Remainder pipe for rounding.
  logic [tds_pkg::DIV_STAGES-1:0] dv_vld_r;
  logic [tds_pkg::DIV_STAGES-1:0] dv_neg_r;
  logic [tds_pkg::VAL_W-1:0]      dv_val_r [tds_pkg::DIV_STAGES];
  logic [tds_pkg::STEP_W-1:0]     dv_rem_r [tds_pkg::DIV_STAGES];
  logic [tds_pkg::DIV_STAGES-1:0] dv_vld_in;
  logic [tds_pkg::DIV_STAGES-1:0] dv_neg_in;
  logic [tds_pkg::VAL_W-1:0]      dv_val_in [tds_pkg::DIV_STAGES];
  logic [tds_pkg::STEP_W-1:0]     dv_rem_in [tds_pkg::DIV_STAGES];
  logic [tds_pkg::STEP_W-1:0]     dv_rem_nx [tds_pkg::DIV_STAGES];

  // Result and output buffer.
  logic [tds_pkg::XQ_W-1:0]       fin_q;
  logic [tds_pkg::VAL_W:0]        fin_r;
  logic [tds_pkg::OUT_W-1:0]      fin_val;
  logic                           push;
  logic                           out_vld_r;
  logic [tds_pkg::OUT_W-1:0]      out_data_r;
  logic                           skid_vld_r;
  logic [tds_pkg::OUT_W-1:0]      skid_data_r;

  // Configuration port.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_mode_r  <= tds_pkg::MODE_TABLE;
      min_value_r  <= '0;
      mean_value_r <= '0;
      round_step_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tds_pkg::cfg_reg_t'(cfg_index))
        tds_pkg::REG_DIST_MODE:  dist_mode_r  <= cfg_data[0];
        tds_pkg::REG_MIN_VALUE:  min_value_r  <= cfg_data;
        tds_pkg::REG_MEAN_VALUE: mean_value_r <= cfg_data;
        tds_pkg::REG_ROUND_STEP: round_step_r <= cfg_data[tds_pkg::STEP_W-1:0];
      endcase
    end
  end

  // The spread |mean - min| and its sign are retimed off the multiplier path.
  always_ff @(posedge clk) begin
    neg_r   <= (mean_value_r < min_value_r);
    d_r     <= (mean_value_r < min_value_r) ? (min_value_r - mean_value_r)
                                            : (mean_value_r - min_value_r);
    rs_nz_r <= (round_step_r != '0);
  end

  // The whole pipe moves together; the skid register absorbs the one result
  // that is in flight when the output stalls.
  assign pipe_en  = !skid_vld_r;
  assign in_ready = pipe_en;
  assign in_acc   = in_valid && in_ready;
  assign ram_we   = in_acc && (in_kind == tds_pkg::KIND_WRITE) &&
                    (32'(in_entry_index) < tds_pkg::TABLE_ENTRIES);
  assign sel_prod = tds_pkg::PROD_W'(in_probability) *
                    tds_pkg::PROD_W'(tds_pkg::TABLE_ENTRIES);

  tds_ram #(
    .WIDTH (2 * tds_pkg::ENTRY_W),
    .DEPTH (tds_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tds_pkg::IDX_W'(in_entry_index)),
    .wdata ({in_entry_base, in_entry_range}),
    .re    (pipe_en),
    .raddr (sel_prod[tds_pkg::PROD_W-1:tds_pkg::PROB_W]),
    .rdata (ram_rdata)
  );

  // Datapath stages ahead of the rounding pipe.
  assign rf_prod = (2 * tds_pkg::ENTRY_W)'(ram_rdata[tds_pkg::ENTRY_W-1:0]) *
                   (2 * tds_pkg::ENTRY_W)'(s1_f_r);

  assign s5_sum   = tds_pkg::SUM_W'({s4_ph_r, {(tds_pkg::CFG_W / 2){1'b0}}}) +
                    tds_pkg::SUM_W'(s4_pl_r);
  assign s5_shift = (dist_mode_r == tds_pkg::MODE_TABLE) ? (s5_sum >> 8) : (s5_sum >> 15);

  assign s6_base16 = (tds_pkg::VAL_W + 1)'({min_value_r, 16'b0});
  assign s7_sum    = (tds_pkg::VAL_W + 1)'(s6_v_r[tds_pkg::VAL_W-1:0]) +
                     (tds_pkg::VAL_W + 1)'({round_step_r, 15'b0});

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_p_r    <= in_probability;
      s1_f_r    <= sel_prod[tds_pkg::PROB_W-1:0];
      s2_base_r <= ram_rdata[2*tds_pkg::ENTRY_W-1:tds_pkg::ENTRY_W];
      s2_rf_r   <= rf_prod[2*tds_pkg::ENTRY_W-1:tds_pkg::ENTRY_W];
      s2_p_r    <= s1_p_r;
      s3_x_r    <= (dist_mode_r == tds_pkg::MODE_TABLE)
                   ? tds_pkg::X_W'(s2_base_r) + tds_pkg::X_W'(s2_rf_r)
                   : tds_pkg::X_W'(s2_p_r);
      s4_pl_r   <= tds_pkg::PART_W'(s3_x_r) *
                   tds_pkg::PART_W'(d_r[tds_pkg::CFG_W/2-1:0]);
      s4_ph_r   <= tds_pkg::PART_W'(s3_x_r) *
                   tds_pkg::PART_W'(d_r[tds_pkg::CFG_W-1:tds_pkg::CFG_W/2]);
      s5_mag_r  <= (s5_shift > tds_pkg::SUM_W'(tds_pkg::MAG_CAP))
                   ? tds_pkg::MAG_CAP : s5_shift[tds_pkg::MAG_W-1:0];
      s6_v_r    <= neg_r ? s6_base16 - (tds_pkg::VAL_W + 1)'(s5_mag_r)
                         : s6_base16 + (tds_pkg::VAL_W + 1)'(s5_mag_r);
      s7_neg_r  <= s6_v_r[tds_pkg::VAL_W];
      // With rounding on, carry (|v| + step/2) >> 16 as the dividend.
      s7_val_r  <= rs_nz_r
                   ? tds_pkg::VAL_W'(s7_sum[tds_pkg::VAL_W:16])
                   : s6_v_r[tds_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_r <= in_acc && (in_kind == tds_pkg::KIND_DRAW);
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
  end

  // Restoring remainder pipe: one dividend bit per stage, remainder mod step.
  for (genvar g = 0; g < tds_pkg::DIV_STAGES; g++) begin : g_div
    logic [tds_pkg::STEP_W:0] part;
    logic [tds_pkg::STEP_W:0] diff;

    if (g == 0) begin : g_first
      assign dv_vld_in[g] = s7_vld_r;
      assign dv_neg_in[g] = s7_neg_r;
      assign dv_val_in[g] = s7_val_r;
      assign dv_rem_in[g] = '0;
    end else begin : g_next
      assign dv_vld_in[g] = dv_vld_r[g-1];
      assign dv_neg_in[g] = dv_neg_r[g-1];
      assign dv_val_in[g] = dv_val_r[g-1];
      assign dv_rem_in[g] = dv_rem_r[g-1];
    end

    assign part          = {dv_rem_in[g], dv_val_in[g][tds_pkg::XQ_W-1-g]};
    assign diff          = part - {1'b0, round_step_r};
    assign dv_rem_nx[g]  = diff[tds_pkg::STEP_W] ? part[tds_pkg::STEP_W-1:0]
                                                 : diff[tds_pkg::STEP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < tds_pkg::DIV_STAGES; i++) begin
        dv_val_r[i] <= dv_val_in[i];
        dv_rem_r[i] <= dv_rem_nx[i];
        dv_neg_r[i] <= dv_neg_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
    end else if (pipe_en) begin
      dv_vld_r <= dv_vld_in;
    end
  end

  // Rounded value is the dividend less its remainder, back in Q.16.
  assign fin_q = dv_val_r[tds_pkg::DIV_LAST][tds_pkg::XQ_W-1:0] -
                 tds_pkg::XQ_W'(dv_rem_r[tds_pkg::DIV_LAST]);
  assign fin_r = rs_nz_r ? {fin_q, 16'b0} : {1'b0, dv_val_r[tds_pkg::DIV_LAST]};

  always_comb begin
    if (dv_neg_r[tds_pkg::DIV_LAST]) begin
      fin_val = '0;
    end else if (fin_r > (tds_pkg::VAL_W + 1)'(tds_pkg::OUT_MAX)) begin
      fin_val = tds_pkg::OUT_MAX;
    end else begin
      fin_val = fin_r[tds_pkg::OUT_W-1:0];
    end
  end

  assign push = pipe_en && dv_vld_r[tds_pkg::DIV_LAST];

  // Output register with one skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= push;
      end
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ready) begin
      out_data_r <= skid_vld_r ? skid_data_r : fin_val;
    end else if (push) begin
      skid_data_r <= fin_val;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_sample_value = out_data_r;

  // The skid entry only fills behind a waiting output beat.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid without a valid output beat");

  // A stalled draw keeps its table read data.
  a_hold_read : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !pipe_en) |=> (s1_vld_r && (ram_rdata === $past(ram_rdata))))
    else $error("table read data lost during stall");

  // The table is never written while the pipe is frozen.
  a_no_write_in_stall : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> pipe_en)
    else $error("table write while pipe stalled");

  // A result arriving at a blocked output lands in the skid entry.
  a_push_to_skid : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready && push) |=> skid_vld_r)
    else $error("result dropped at blocked output");

endmodule

FILE: design/tds_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tds_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sim/tds_checker.sv
// ----------------------------------------------------------------------------
// Table distribution sampler checker
// Watches the register, item and sample channels of the sampler core, keeps
// its own copy of the registers and the segment table, predicts each sample
// and compares it with the sample that leaves the core, in order.
// ----------------------------------------------------------------------------
module tds_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  tds_pkg::cfg_reg_t             cfg_index,
  input  logic [tds_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [tds_pkg::KIND_W-1:0]    in_kind,
  input  logic [tds_pkg::EIDX_W-1:0]    in_entry_index,
  input  logic [tds_pkg::ENTRY_W-1:0]   in_entry_base,
  input  logic [tds_pkg::ENTRY_W-1:0]   in_entry_range,
  input  logic [tds_pkg::PROB_W-1:0]    in_probability,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [tds_pkg::OUT_W-1:0]     out_sample_value,
  output int                            fail_count,
  output int                            samples_pending,
  output int                            samples_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import tds_pkg::*;

  typedef struct {
    logic [OUT_W-1:0]  value;
    logic [PROB_W-1:0] prob;
  } sample_exp_t;

  sample_exp_t          expected_samples[$];
  logic [ENTRY_W-1:0]   seg_base[TABLE_ENTRIES];
  logic [ENTRY_W-1:0]   seg_range[TABLE_ENTRIES];
  logic                 mode_r;
  logic [CFG_W-1:0]     min_r;
  logic [CFG_W-1:0]     mean_r;
  logic [STEP_W-1:0]    step_r;

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    fail_count++;
  endtask

  // Expected Q40.16 sample for one fraction under the current registers.
  function automatic logic [OUT_W-1:0] shape_sample(input logic [PROB_W-1:0] prob);
    logic         below;
    logic [127:0] span;
    logic [127:0] prod;
    logic [127:0] t;
    logic [127:0] mag;
    logic [127:0] origin;
    logic [127:0] m;
    logic [127:0] s;
    int           idx;
    below = mean_r < min_r;
    span  = below ? 128'(min_r - mean_r) : 128'(mean_r - min_r);
    if (mode_r == MODE_TABLE) begin
      prod = 128'(prob) * 128'(TABLE_ENTRIES);
      idx  = int'(prod[63:32]);
      t    = 128'(seg_base[idx]) + ((128'(seg_range[idx]) * 128'(prod[31:0])) >> 32);
      mag  = (t * span) >> 8;
      if (mag > 128'(MAG_CAP))
        mag = 128'(MAG_CAP);
    end else begin
      mag = (128'(prob) * span) >> 15;
    end
    origin = 128'(min_r) << 16;
    // A negative value stays at or below zero through rounding, so it clamps.
    if (below && mag > origin)
      return '0;
    m = below ? origin - mag : origin + mag;
    if (step_r != '0) begin
      s = 128'(step_r) << 16;
      m = ((2 * m + s) / (2 * s)) * s;
    end
    if (m > 128'(OUT_MAX))
      m = 128'(OUT_MAX);
    return m[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    sample_exp_t exp_s;
    if (!rst_n) begin
      mode_r = MODE_TABLE;
      min_r  = '0;
      mean_r = '0;
      step_r = '0;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIST_MODE:  mode_r = cfg_data[0];
          REG_MIN_VALUE:  min_r  = cfg_data;
          REG_MEAN_VALUE: mean_r = cfg_data;
          REG_ROUND_STEP: step_r = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_error($sformatf("unexpected sample %h", out_sample_value));
        end else begin
          exp_s = expected_samples.pop_front();
          samples_checked++;
          if (out_sample_value !== exp_s.value)
            report_error($sformatf("sample_value %h, expected %h for probability %h",
                                   out_sample_value, exp_s.value, exp_s.prob));
        end
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_DRAW) begin
          exp_s.prob  = in_probability;
          exp_s.value = shape_sample(in_probability);
          expected_samples.push_back(exp_s);
        end else if (int'(in_entry_index) < TABLE_ENTRIES) begin
          seg_base[in_entry_index]  = in_entry_base;
          seg_range[in_entry_index] = in_entry_range;
        end
      end
    end
    samples_pending <= expected_samples.size();
  end

endmodule

FILE: sim/table_distribution_sampler_core_tb.sv
// ----------------------------------------------------------------------------
// Table distribution sampler testbench
// Drives register settings, segment table writes and draw beats into the
// sampler core with random idling on both sides; the checker predicts and
// compares every sample, and this module gives the verdict.
// ----------------------------------------------------------------------------
module table_distribution_sampler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tds_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_BEATS  = 48;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [KIND_W-1:0]    in_kind;
  logic [EIDX_W-1:0]    in_entry_index;
  logic [ENTRY_W-1:0]   in_entry_base;
  logic [ENTRY_W-1:0]   in_entry_range;
  logic [PROB_W-1:0]    in_probability;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_W-1:0]     out_sample_value;

  int                   fail_count;
  int                   samples_pending;
  int                   samples_checked;

  logic                 calm    = 1'b0;
  logic                 hold_on = 1'b0;
  int                   held    = 0;
  logic                 written[TABLE_ENTRIES];
  int                   beats_sent;
  int                   draws_sent;
  int                   writes_sent;
  int                   unused_writes;
  int                   settings_used;

  always #6 clk = ~clk;

  table_distribution_sampler_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_entry_index   (in_entry_index),
    .in_entry_base    (in_entry_base),
    .in_entry_range   (in_entry_range),
    .in_probability   (in_probability),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value)
  );

  tds_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_entry_index   (in_entry_index),
    .in_entry_base    (in_entry_base),
    .in_entry_range   (in_entry_range),
    .in_probability   (in_probability),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .fail_count       (fail_count),
    .samples_pending  (samples_pending),
    .samples_checked  (samples_checked)
  );

  // Sample sink. Once asked, it refuses samples for a long stretch so that the
  // core backs up into its input.
  always @(posedge clk) begin
    if (hold_on && held < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      held      <= held + 1;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Fractions in [lo, hi] select table entry k.
  function automatic logic [PROB_W-1:0] entry_lo(input int k);
    return PROB_W'((64'(k) * 64'h1_0000_0000 + 64'(TABLE_ENTRIES - 1)) / TABLE_ENTRIES);
  endfunction

  function automatic logic [PROB_W-1:0] entry_hi(input int k);
    return PROB_W'((64'(k + 1) * 64'h1_0000_0000 + 64'(TABLE_ENTRIES - 1)) / TABLE_ENTRIES
                   - 64'd1);
  endfunction

  // Fraction landing on some entry that has been written.
  function automatic logic [PROB_W-1:0] pick_table_prob();
    int          k;
    logic [63:0] lo;
    logic [63:0] hi;
    do
      k = $urandom_range(0, TABLE_ENTRIES - 1);
    while (!written[k]);
    lo = 64'(entry_lo(k));
    hi = 64'(entry_hi(k));
    case ($urandom_range(0, 7))
      0:       return PROB_W'(lo);
      1:       return PROB_W'(hi);
      default: return PROB_W'(lo + 64'($urandom) % (hi - lo + 64'd1));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_value();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_W'($urandom_range(0, 1000));
      2:       return CFG_W'($urandom_range(0, 32'hFF_FFFF));
      3:       return wide[CFG_W-1:0];
      4:       return '1;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [EIDX_W-1:0] idx,
                           input logic [ENTRY_W-1:0] base, input logic [ENTRY_W-1:0] rng,
                           input logic [PROB_W-1:0] prob);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= idx;
    in_entry_base  <= base;
    in_entry_range <= rng;
    in_probability <= prob;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (kind == KIND_DRAW) begin
      draws_sent++;
    end else begin
      writes_sent++;
      if (int'(idx) < TABLE_ENTRIES)
        written[idx] = 1'b1;
      else
        unused_writes++;
    end
  endtask

  task automatic write_entry(input int idx, input logic [ENTRY_W-1:0] base,
                             input logic [ENTRY_W-1:0] rng);
    send_beat(KIND_WRITE, EIDX_W'(idx), base, rng, $urandom);
  endtask

  task automatic draw(input logic [PROB_W-1:0] prob);
    send_beat(KIND_DRAW, EIDX_W'($urandom), $urandom, $urandom, prob);
  endtask

  task automatic wait_samples();
    in_valid <= 1'b0;
    do @(posedge clk); while (samples_pending != 0);
  endtask

  // Table writes make no sample, so give the pipe its full depth after the
  // last sample before touching the registers.
  task automatic drain();
    wait_samples();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic mode, input logic [CFG_W-1:0] min_v,
                            input logic [CFG_W-1:0] mean_v, input logic [STEP_W-1:0] step);
    drain();
    write_reg(REG_DIST_MODE, CFG_W'(mode));
    write_reg(REG_MIN_VALUE, min_v);
    write_reg(REG_MEAN_VALUE, mean_v);
    write_reg(REG_ROUND_STEP, CFG_W'(step));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_beat(input logic mode);
    int               r;
    logic [ENTRY_W-1:0] base;
    logic [ENTRY_W-1:0] rng;
    logic [PROB_W-1:0]  prob;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      // Normalized segments half the time, arbitrary bit patterns otherwise.
      if ($urandom_range(0, 1) == 0) begin
        base = $urandom_range(0, 32'h0200_0000);
        rng  = $urandom_range(0, 32'h0100_0000);
      end else begin
        base = $urandom;
        rng  = $urandom;
      end
      write_entry(r < 3 ? $urandom_range(TABLE_ENTRIES, 127) : $urandom_range(0, 99),
                  base, rng);
    end else begin
      if (mode == MODE_TABLE)
        prob = pick_table_prob();
      else if (r > 96)
        prob = (r == 99) ? '1 : '0;
      else
        prob = $urandom;
      draw(prob);
    end
  endtask

  initial begin
    logic             mode;
    logic [CFG_W-1:0] min_v;
    logic [CFG_W-1:0] mean_v;
    logic [CFG_W-1:0] swap;
    logic [STEP_W-1:0] step;
    int               n_beats;

    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_DIST_MODE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_kind        = KIND_WRITE;
    in_entry_index = '0;
    in_entry_base  = '0;
    in_entry_range = '0;
    in_probability = '0;
    foreach (written[k])
      written[k] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: table extremes, unused indexes, both modes, cap and clamps.
    set_config(MODE_TABLE, 40'd1000, 40'd5000, 32'd0);
    write_entry(0, 32'h0000_0000, 32'h0000_0000);
    write_entry(TABLE_ENTRIES - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_entry(50, 32'h0100_0000, 32'h0080_0000);
    write_entry(127, $urandom, $urandom);
    write_entry(TABLE_ENTRIES, $urandom, $urandom);
    draw(32'h0000_0000);
    draw(32'hFFFF_FFFF);
    draw(entry_lo(50));
    draw(entry_hi(50));
    // Widest span: the top entry overflows the magnitude cap.
    set_config(MODE_TABLE, 40'd0, '1, 32'd0);
    draw(32'hFFFF_FFFF);
    draw(entry_hi(50));
    // Mean below min with the coarsest rounding step.
    set_config(MODE_TABLE, '1, 40'd0, '1);
    draw(32'h0000_0000);
    draw(32'hFFFF_FFFF);
    set_config(MODE_UNIFORM, 40'd0, '1, 32'd0);
    draw(32'h0000_0000);
    draw(32'hFFFF_FFFF);
    draw(32'h8000_0000);
    set_config(MODE_UNIFORM, 40'd12345, 40'd100, 32'd7);
    draw(32'h0000_0000);
    draw(32'hFFFF_FFFF);
    draw($urandom);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode   = $urandom_range(0, 1);
      min_v  = pick_value();
      mean_v = pick_value();
      if ($urandom_range(0, 9) < 6 && mean_v < min_v) begin
        swap   = mean_v;
        mean_v = min_v;
        min_v  = swap;
      end
      case ($urandom_range(0, 4))
        0, 1:    step = '0;
        2:       step = $urandom_range(1, 16);
        3:       step = $urandom_range(1, 100000);
        default: step = $urandom;
      endcase
      set_config(mode, min_v, mean_v, step);
      n_beats = PHASE_BEATS;
      if (ph == 1) begin
        hold_on <= 1'b1;
        n_beats = 3 * PHASE_BEATS;
      end
      if (ph == 3)
        calm <= 1'b1;
      if (ph == 4)
        calm <= 1'b0;
      for (int n = 0; n < n_beats; n++) begin
        if (ph == 5 && n == n_beats / 2)
          wait_samples();
        random_beat(mode);
      end
    end
    drain();

    $display("Drove %0d beats (%0d draws, %0d table writes, %0d to unused indexes) under %0d register settings.",
             beats_sent, draws_sent, writes_sent, unused_writes, settings_used);
    $display("Checked %0d samples, with one long sink stall and one drained pause.",
             samples_checked);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
design/tds_pkg.sv
design/tds_ram.sv
design/table_distribution_sampler_core.sv
sim/tds_checker.sv
sim/table_distribution_sampler_core_tb.sv
